FILE: sv/pfsc_pkg.sv
// Shared types, constants and symbol helpers for the 6x6 Playfair-style cipher core.
// No dependencies; used by playfair_square_cipher_core.
package pfsc_pkg;

  localparam int Side     = 6;
  localparam int Cells    = Side * Side;
  localparam int SymW     = $clog2(Cells);
  localparam int CharW    = 8;

  localparam logic [SymW-1:0]  CellsCount = SymW'(Cells);
  localparam logic [SymW-1:0]  PadSym     = SymW'(8'h58 - 8'h41);  // 'X'
  localparam logic [SymW-1:0]  LastSym    = SymW'(Cells - 1);
  localparam logic [CharW-1:0] ChA        = 8'h41;
  localparam logic [CharW-1:0] ChZ        = 8'h5A;
  localparam logic [CharW-1:0] Cha        = 8'h61;
  localparam logic [CharW-1:0] Chz        = 8'h7A;
  localparam logic [CharW-1:0] Ch0        = 8'h30;
  localparam logic [CharW-1:0] Ch9        = 8'h39;
  localparam int               Letters    = 26;

  typedef enum logic [1:0] {
    MODE_KEY    = 2'd0,
    MODE_FINISH = 2'd1,
    MODE_MSG    = 2'd2,
    MODE_END    = 2'd3
  } mode_e;

  typedef struct packed {
    logic            ok;
    logic [SymW-1:0] code;
  } sym_t;

  // ASCII byte to symbol code: A..Z -> 0..25, 0..9 -> 26..35, case folded.
  function automatic sym_t sym_of(input logic [CharW-1:0] c);
    sym_t s;
    s.ok   = 1'b0;
    s.code = '0;
    if (c >= ChA && c <= ChZ) begin
      s.ok   = 1'b1;
      s.code = SymW'(c - ChA);
    end else if (c >= Cha && c <= Chz) begin
      s.ok   = 1'b1;
      s.code = SymW'(c - Cha);
    end else if (c >= Ch0 && c <= Ch9) begin
      s.ok   = 1'b1;
      s.code = SymW'(c - Ch0) + SymW'(Letters);
    end
    return s;
  endfunction

  function automatic logic [CharW-1:0] char_of(input logic [SymW-1:0] s);
    logic [CharW-1:0] c;
    if (s < SymW'(Letters)) c = ChA + CharW'(s);
    else                    c = Ch0 + CharW'(s - SymW'(Letters));
    return c;
  endfunction

  // Row of a cell: p/6 as (p*43)>>8, exact for p < 36.
  function automatic logic [2:0] row_of(input logic [SymW-1:0] p);
    logic [11:0] prod;
    prod = 12'(p) * 12'd43;
    return prod[10:8];
  endfunction

  function automatic logic [2:0] col_of(input logic [SymW-1:0] p);
    logic [2:0]      r;
    logic [SymW-1:0] base;
    r    = row_of(p);
    base = (SymW'(r) << 2) + (SymW'(r) << 1);
    return 3'(p - base);
  endfunction

  function automatic logic [SymW-1:0] cell_at(input logic [2:0] r, input logic [2:0] c);
    return (SymW'(r) << 2) + (SymW'(r) << 1) + SymW'(c);
  endfunction

endpackage

FILE: sv/pfsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the key square and the symbol position table.
module pfsc_ram #(
  parameter int Width = 6,
  parameter int Depth = 36
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/playfair_square_cipher_core.sv
// Playfair-style cipher over a 6x6 square of A-Z and 0-9.
// Depends on pfsc_pkg and pfsc_ram.
//
// Usage: one input channel (mode_i, in_char_i) and one output channel
// (out_char_o, pair_end_o), both valid/ready. Mode 0 feeds key characters,
// mode 1 finishes the square, mode 2 feeds message characters, mode 3 ends
// the message (an odd leftover is padded with X).
// Handling per input item, shaped by the sequencer and the single read port of
// each table RAM:
//   key character, first message character of a pair, ignored item: accepted without leaving S_IDLE
//   finish: walks all 36 symbols (one symbol checked and placed per cycle)
//   second message character or end with a leftover: two results, via S_RDP,
//   S_RDQ, S_CAP and S_KRD; then S_OUT0 and S_OUT1 register one result each.
// in_ready_o is low while an item is being worked on. Results sit in one
// output register; a stalled receiver holds the sequencer in its output
// states, and the next item is accepted once the last result is registered.
// Reset clears the seen mask, fill count, square-ready and held flags; the
// key square must be rebuilt after every reset. Table contents are not
// cleared, since each entry is written before it is ever read.
module playfair_square_cipher_core
  import pfsc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       mode_i,
  input  logic [7:0]       in_char_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_char_o,
  output logic             pair_end_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_FILL = 8'b0000_0010,
    S_RDP  = 8'b0000_0100,
    S_RDQ  = 8'b0000_1000,
    S_CAP  = 8'b0001_0000,
    S_KRD  = 8'b0010_0000,
    S_OUT0 = 8'b0100_0000,
    S_OUT1 = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [SymW-1:0]   fill_q, fill_d;
  logic [Cells-1:0]  seen_q, seen_d;
  logic              sq_ready_q, sq_ready_d;
  logic              held_valid_q, held_valid_d;
  logic [SymW-1:0]   held_q, held_d;
  logic [SymW-1:0]   sym_q, sym_d;
  logic [SymW-1:0]   idx_q, idx_d;
  logic [SymW-1:0]   pp_q, pp_d;
  logic [SymW-1:0]   pq_q, pq_d;
  logic              out_valid_q, out_valid_d;
  logic [CharW-1:0]  out_char_q, out_char_d;
  logic              pair_end_q, pair_end_d;

  logic              accept;
  logic              slot_free;
  logic              full;
  sym_t              in_sym;
  mode_e             mode;
  logic              place_en;
  logic [SymW-1:0]   place_sym;
  logic [SymW-1:0]   place_raddr;
  logic [SymW-1:0]   place_rdata;
  logic [SymW-1:0]   key_raddr;
  logic [SymW-1:0]   key_rdata;
  logic [SymW-1:0]   addr_a, addr_b;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign full       = (fill_q == CellsCount);
  assign in_sym     = sym_of(in_char_i);
  assign mode       = mode_e'(mode_i);

  // Swap targets: row(p) with col(q), then row(q) with col(p).
  assign addr_a = cell_at(row_of(pp_q), col_of(pq_q));
  assign addr_b = cell_at(row_of(pq_q), col_of(pp_q));

  always_comb begin
    place_sym = idx_q;
    place_en  = 1'b0;
    if (state_q == S_IDLE) begin
      place_sym = in_sym.code;
      place_en  = accept && (mode == MODE_KEY) && !sq_ready_q && in_sym.ok &&
                  !seen_q[in_sym.code] && !full;
    end else if (state_q == S_FILL) begin
      place_en  = !seen_q[idx_q] && !full;
    end
  end

  assign place_raddr = (state_q == S_RDP) ? held_q : sym_q;
  assign key_raddr   = ((state_q == S_OUT1) || ((state_q == S_OUT0) && slot_free)) ?
                       addr_b : addr_a;

  pfsc_ram #(.Width(SymW), .Depth(Cells)) u_key_square (
    .clk_i   (clk_i),
    .we_i    (place_en),
    .waddr_i (fill_q),
    .wdata_i (place_sym),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  pfsc_ram #(.Width(SymW), .Depth(Cells)) u_symbol_place (
    .clk_i   (clk_i),
    .we_i    (place_en),
    .waddr_i (place_sym),
    .wdata_i (fill_q),
    .raddr_i (place_raddr),
    .rdata_o (place_rdata)
  );

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    seen_d       = seen_q;
    sq_ready_d   = sq_ready_q;
    held_valid_d = held_valid_q;
    held_d       = held_q;
    sym_d        = sym_q;
    idx_d        = idx_q;
    pp_d         = pp_q;
    pq_d         = pq_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_char_d   = out_char_q;
    pair_end_d   = pair_end_q;

    if (place_en) begin
      seen_d[place_sym] = 1'b1;
      fill_d            = fill_q + SymW'(1);
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (mode)
            MODE_KEY: ;
            MODE_FINISH: begin
              if (!sq_ready_q) begin
                idx_d   = '0;
                state_d = S_FILL;
              end
            end
            MODE_MSG: begin
              if (sq_ready_q && in_sym.ok) begin
                if (!held_valid_q) begin
                  held_d       = in_sym.code;
                  held_valid_d = 1'b1;
                end else begin
                  sym_d        = in_sym.code;
                  held_valid_d = 1'b0;
                  state_d      = S_RDP;
                end
              end
            end
            MODE_END: begin
              if (sq_ready_q && held_valid_q) begin
                sym_d        = PadSym;
                held_valid_d = 1'b0;
                state_d      = S_RDP;
              end
            end
            default: ;
          endcase
        end
      end
      S_FILL: begin
        idx_d = idx_q + SymW'(1);
        if (idx_q == LastSym) begin
          sq_ready_d = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_RDP: state_d = S_RDQ;
      S_RDQ: begin
        pp_d    = place_rdata;
        state_d = S_CAP;
      end
      S_CAP: begin
        pq_d    = place_rdata;
        state_d = S_KRD;
      end
      S_KRD: state_d = S_OUT0;
      S_OUT0: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = char_of(key_rdata);
          pair_end_d  = 1'b0;
          state_d     = S_OUT1;
        end
      end
      S_OUT1: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = char_of(key_rdata);
          pair_end_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fill_q       <= '0;
      seen_q       <= '0;
      sq_ready_q   <= 1'b0;
      held_valid_q <= 1'b0;
      held_q       <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      seen_q       <= seen_d;
      sq_ready_q   <= sq_ready_d;
      held_valid_q <= held_valid_d;
      held_q       <= held_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q      <= sym_d;
    pp_q       <= pp_d;
    pq_q       <= pq_d;
    out_char_q <= out_char_d;
    pair_end_q <= pair_end_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign pair_end_o  = pair_end_q;

endmodule
